// ===== design/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the RPN stack calculator: character codes,
// token classes, status codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_FEW      = 3'd2;
  localparam logic [2:0] ST_DIVZERO  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_LEFTOVER = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;
  localparam logic [2:0] ST_FULL     = 3'd7;

  typedef enum logic [1:0] {
    CL_NONE  = 2'd0,
    CL_SPACE = 2'd1,
    CL_DIGIT = 2'd2,
    CL_OPER  = 2'd3
  } cls_t;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RD_R    = 9'b000000010,
    S_RD_L    = 9'b000000100,
    S_EXEC    = 9'b000001000,
    S_MULW    = 9'b000010000,
    S_DIV     = 9'b000100000,
    S_WB      = 9'b001000000,
    S_FIN_RD  = 9'b010000000,
    S_FIN_OUT = 9'b100000000
  } state_t;

  localparam logic [DATA_W-1:0] INT_MIN   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_M_ONE = 32'hFFFF_FFFF;

endpackage

// ===== design/rpn_in_if.sv =====
// ----------------------------------------------------------------------------
// rpn_in_if
// Character channel: one expression character per item.
// ----------------------------------------------------------------------------
interface rpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== design/rpn_out_if.sv =====
// ----------------------------------------------------------------------------
// rpn_out_if
// Result channel: final value and status of one expression per item.
// ----------------------------------------------------------------------------
interface rpn_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [2:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== design/rpn_ram.sv =====
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rpn_div.sv =====
// ----------------------------------------------------------------------------
// rpn_div
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating
// toward zero. The caller excludes a zero divisor and MIN / -1.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rpn_pkg::DATA_W-1:0] dividend,
  input  logic [rpn_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [rpn_pkg::DATA_W-1:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] a_r;
  logic [31:0] d_r;
  logic [31:0] rem_r;
  logic        neg_r;

  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        ge;

  assign rem_sh = {rem_r, a_r[31]};
  assign diff   = {1'b0, rem_sh} - {2'b00, d_r};
  assign ge     = !diff[33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend[31] ? (32'd0 - dividend) : dividend;
      d_r   <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem_r <= '0;
      neg_r <= dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : rem_sh[31:0];
      a_r   <= {a_r[30:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - a_r) : a_r;

endmodule

// ===== design/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Evaluates an RPN expression fed one character per item. Operands live in
// a synchronous stack RAM; operators read two entries, compute, write back.
//
//   channel   dir  fields                      handshake
//   in_chan   in   char_code[7:0], last_char   valid/ready
//   out_chan  out  value[31:0], status[2:0]    valid/ready
//
// space, digit or invalid character: IDLE; + and -: RD_R, RD_L, EXEC, WB; *:
// adds MULW; /: adds DIV, held until the divider is done. The last character
// adds FIN_RD, FIN_OUT to read the stack bottom and to wait for out_free.
// Reset is synchronous and clears the sequencer and expression state only;
// stack entries are read only below the count. A result waits in the output
// register while the next expression is already accepted.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  rpn_in_if.sink          in_chan,
  rpn_out_if.source       out_chan
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  rpn_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  rpn_pkg::cls_t   prev_r, prev_nxt;
  logic [2:0]      syn_r, syn_nxt;
  logic [2:0]      eval_r, eval_nxt;
  logic            last_r, last_nxt;
  logic [7:0]      op_r, op_nxt;
  logic [31:0]     r_r, r_nxt;
  logic [31:0]     res_r, res_nxt;
  logic [63:0]     prod_r, prod_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_value_r, out_value_nxt;
  logic [2:0]      out_status_r, out_status_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;

  logic            div_start;
  logic            div_done;
  logic [31:0]     div_quot;

  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   cnt_m2;
  logic [7:0]      digit;

  rpn_pkg::cls_t   acc_cls;
  logic [2:0]      acc_syn;
  logic            acc_healthy;
  logic            is_space, is_digit, is_oper;

  logic [32:0]     sum;
  logic            sum_ovf;
  logic            prod_ovf;
  logic            out_free;
  rpn_pkg::state_t end_state;

  assign cnt_m1   = count_r - CW'(1);
  assign cnt_m2   = count_r - CW'(2);
  assign digit    = in_chan.char_code - rpn_pkg::CH_ZERO;
  assign out_free = !out_valid_r || out_chan.ready;
  assign end_state = last_r ? rpn_pkg::S_FIN_RD : rpn_pkg::S_IDLE;

  // token class and syntax check of the incoming character
  always_comb begin
    is_space = (in_chan.char_code == rpn_pkg::CH_SPACE);
    is_digit = (in_chan.char_code >= rpn_pkg::CH_ZERO) &&
               (in_chan.char_code <= rpn_pkg::CH_NINE);
    is_oper  = (in_chan.char_code == rpn_pkg::CH_PLUS) ||
               (in_chan.char_code == rpn_pkg::CH_MINUS) ||
               (in_chan.char_code == rpn_pkg::CH_STAR) ||
               (in_chan.char_code == rpn_pkg::CH_SLASH);
    acc_syn  = syn_r;
    if (is_digit) begin
      acc_cls = rpn_pkg::CL_DIGIT;
    end else if (is_oper) begin
      acc_cls = rpn_pkg::CL_OPER;
    end else begin
      acc_cls = rpn_pkg::CL_SPACE;
      if (!is_space && acc_syn == rpn_pkg::ST_OK) begin
        acc_syn = rpn_pkg::ST_INVALID;
      end
    end
    if (acc_syn == rpn_pkg::ST_OK) begin
      priority if (acc_cls == rpn_pkg::CL_OPER && prev_r == rpn_pkg::CL_NONE) begin
        acc_syn = rpn_pkg::ST_FEW;
      end else if (acc_cls == rpn_pkg::CL_OPER && prev_r == rpn_pkg::CL_DIGIT) begin
        acc_syn = rpn_pkg::ST_INVALID;
      end else if (acc_cls == rpn_pkg::CL_DIGIT &&
                   (prev_r == rpn_pkg::CL_OPER || prev_r == rpn_pkg::CL_DIGIT)) begin
        acc_syn = rpn_pkg::ST_INVALID;
      end else begin
        acc_syn = rpn_pkg::ST_OK;
      end
    end
    acc_healthy = (acc_syn == rpn_pkg::ST_OK) && (eval_r == rpn_pkg::ST_OK);
  end

  // add / subtract with left operand from the ram, right from r_r
  always_comb begin
    if (op_r == rpn_pkg::CH_MINUS) begin
      sum = {ram_rdata[31], ram_rdata} - {r_r[31], r_r};
    end else begin
      sum = {ram_rdata[31], ram_rdata} + {r_r[31], r_r};
    end
    sum_ovf  = sum[32] != sum[31];
    prod_ovf = !((&prod_r[63:31]) || !(|prod_r[63:31]));
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    prev_nxt       = prev_r;
    syn_nxt        = syn_r;
    eval_nxt       = eval_r;
    last_nxt       = last_r;
    op_nxt         = op_r;
    r_nxt          = r_r;
    res_nxt        = res_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = res_r;
    ram_raddr      = '0;
    div_start      = 1'b0;

    unique case (state_r)
      rpn_pkg::S_IDLE: begin
        if (in_chan.valid) begin
          prev_nxt  = acc_cls;
          syn_nxt   = acc_syn;
          last_nxt  = in_chan.last_char;
          op_nxt    = in_chan.char_code;
          state_nxt = in_chan.last_char ? rpn_pkg::S_FIN_RD : rpn_pkg::S_IDLE;
          if (acc_healthy && acc_cls == rpn_pkg::CL_DIGIT) begin
            if (count_r == CW'(STACK_DEPTH)) begin
              eval_nxt = rpn_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = 32'(digit);
              count_nxt = count_r + CW'(1);
            end
          end else if (acc_healthy && acc_cls == rpn_pkg::CL_OPER) begin
            if (count_r < CW'(2)) begin
              eval_nxt = rpn_pkg::ST_FEW;
            end else begin
              state_nxt = rpn_pkg::S_RD_R;
            end
          end
        end
      end
      rpn_pkg::S_RD_R: begin
        ram_raddr = cnt_m1[AW-1:0];
        state_nxt = rpn_pkg::S_RD_L;
      end
      rpn_pkg::S_RD_L: begin
        ram_raddr = cnt_m2[AW-1:0];
        r_nxt     = ram_rdata;
        state_nxt = rpn_pkg::S_EXEC;
      end
      rpn_pkg::S_EXEC: begin
        priority if (op_r == rpn_pkg::CH_PLUS || op_r == rpn_pkg::CH_MINUS) begin
          if (sum_ovf) begin
            eval_nxt  = rpn_pkg::ST_OVERFLOW;
            state_nxt = end_state;
          end else begin
            res_nxt   = sum[31:0];
            state_nxt = rpn_pkg::S_WB;
          end
        end else if (op_r == rpn_pkg::CH_STAR) begin
          prod_nxt  = $signed(ram_rdata) * $signed(r_r);
          state_nxt = rpn_pkg::S_MULW;
        end else begin
          if (r_r == '0) begin
            eval_nxt  = rpn_pkg::ST_DIVZERO;
            state_nxt = end_state;
          end else if (ram_rdata == rpn_pkg::INT_MIN && r_r == rpn_pkg::INT_M_ONE) begin
            eval_nxt  = rpn_pkg::ST_OVERFLOW;
            state_nxt = end_state;
          end else begin
            div_start = 1'b1;
            state_nxt = rpn_pkg::S_DIV;
          end
        end
      end
      rpn_pkg::S_MULW: begin
        if (prod_ovf) begin
          eval_nxt  = rpn_pkg::ST_OVERFLOW;
          state_nxt = end_state;
        end else begin
          res_nxt   = prod_r[31:0];
          state_nxt = rpn_pkg::S_WB;
        end
      end
      rpn_pkg::S_DIV: begin
        if (div_done) begin
          res_nxt   = div_quot;
          state_nxt = rpn_pkg::S_WB;
        end
      end
      rpn_pkg::S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m2[AW-1:0];
        ram_wdata = res_r;
        count_nxt = cnt_m1;
        state_nxt = end_state;
      end
      rpn_pkg::S_FIN_RD: begin
        state_nxt = rpn_pkg::S_FIN_OUT;
      end
      rpn_pkg::S_FIN_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          priority if (syn_r != rpn_pkg::ST_OK) begin
            out_status_nxt = syn_r;
          end else if (eval_r != rpn_pkg::ST_OK) begin
            out_status_nxt = eval_r;
          end else if (count_r == '0) begin
            out_status_nxt = rpn_pkg::ST_EMPTY;
          end else if (count_r > CW'(1)) begin
            out_status_nxt = rpn_pkg::ST_LEFTOVER;
          end else begin
            out_status_nxt = rpn_pkg::ST_OK;
            out_value_nxt  = ram_rdata;
          end
          count_nxt = '0;
          prev_nxt  = rpn_pkg::CL_NONE;
          syn_nxt   = rpn_pkg::ST_OK;
          eval_nxt  = rpn_pkg::ST_OK;
          state_nxt = rpn_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rpn_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpn_pkg::S_IDLE;
      count_r     <= '0;
      prev_r      <= rpn_pkg::CL_NONE;
      syn_r       <= rpn_pkg::ST_OK;
      eval_r      <= rpn_pkg::ST_OK;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      prev_r      <= prev_nxt;
      syn_r       <= syn_nxt;
      eval_r      <= eval_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    r_r          <= r_nxt;
    res_r        <= res_nxt;
    prod_r       <= prod_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  rpn_ram #(
    .WIDTH (rpn_pkg::DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ram_rdata),
    .divisor  (r_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign in_chan.ready   = (state_r == rpn_pkg::S_IDLE);
  assign out_chan.valid  = out_valid_r;
  assign out_chan.value  = out_value_r;
  assign out_chan.status = out_status_r;

endmodule

// ===== verif/rpn_eval_checker.sv =====
// ----------------------------------------------------------------------------
// rpn_eval_checker
// Watches the character and result channels of the RPN stack calculator.
// Every accepted character runs through an independent evaluator that keeps
// its own operand stack and fault state. The expected value and status of
// each finished expression are queued and compared, field by field, with the
// results that leave the block, in order.
// ----------------------------------------------------------------------------
module rpn_eval_checker #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  rpn_in_if    in_chan,
  rpn_out_if   out_chan,
  output int   mismatch_count,
  output int   results_owed
);
  import rpn_pkg::*;

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [2:0]        status;
  } calc_result_t;

  logic [DATA_W-1:0] operands [STACK_DEPTH];
  int unsigned       depth_count;
  cls_t              prev_cls;
  logic [2:0]        syntax_err;
  logic [2:0]        eval_err;
  calc_result_t      expected_results [$];
  calc_result_t      want;
  int                errors = 0;

  assign mismatch_count = errors;

  task automatic clear_expression();
    depth_count = 0;
    prev_cls    = CL_NONE;
    syntax_err  = ST_OK;
    eval_err    = ST_OK;
  endtask

  task automatic apply_op(input logic [7:0] op);
    longint lhs;
    longint rhs;
    longint res;
    if (depth_count < 2) begin
      eval_err = ST_FEW;
      return;
    end
    rhs = longint'($signed(operands[depth_count-1]));
    lhs = longint'($signed(operands[depth_count-2]));
    case (op)
      CH_PLUS:  res = lhs + rhs;
      CH_MINUS: res = lhs - rhs;
      CH_STAR:  res = lhs * rhs;
      default: begin
        if (rhs == 0) begin
          eval_err = ST_DIVZERO;
          return;
        end
        res = lhs / rhs;
      end
    endcase
    if (res > I32_MAX || res < I32_MIN) begin
      eval_err = ST_OVERFLOW;
      return;
    end
    depth_count--;
    operands[depth_count-1] = res[DATA_W-1:0];
  endtask

  task automatic evaluate_char(input logic [7:0] ch, input logic last);
    cls_t         cls;
    calc_result_t res;
    if (ch == CH_SPACE) begin
      cls = CL_SPACE;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      cls = CL_DIGIT;
    end else if (ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
      cls = CL_OPER;
    end else begin
      // unknown characters act as separators
      cls = CL_SPACE;
      if (syntax_err == ST_OK) syntax_err = ST_INVALID;
    end

    if (syntax_err == ST_OK) begin
      if (cls == CL_OPER && prev_cls == CL_NONE) syntax_err = ST_FEW;
      else if (cls == CL_OPER && prev_cls == CL_DIGIT) syntax_err = ST_INVALID;
      else if (cls == CL_DIGIT && (prev_cls == CL_OPER || prev_cls == CL_DIGIT))
        syntax_err = ST_INVALID;
    end

    // stack frozen after any fault
    if (syntax_err == ST_OK && eval_err == ST_OK) begin
      if (cls == CL_DIGIT) begin
        if (depth_count >= STACK_DEPTH) begin
          eval_err = ST_FULL;
        end else begin
          operands[depth_count] = 32'(ch - CH_ZERO);
          depth_count++;
        end
      end else if (cls == CL_OPER) begin
        apply_op(ch);
      end
    end
    prev_cls = cls;

    if (last) begin
      res.value = '0;
      if (syntax_err != ST_OK) res.status = syntax_err;
      else if (eval_err != ST_OK) res.status = eval_err;
      else if (depth_count == 0) res.status = ST_EMPTY;
      else if (depth_count > 1) res.status = ST_LEFTOVER;
      else begin
        res.status = ST_OK;
        res.value  = operands[0];
      end
      expected_results.push_back(res);
      clear_expression();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_expression();
      expected_results.delete();
    end else begin
      if (in_chan.valid && in_chan.ready)
        evaluate_char(in_chan.char_code, in_chan.last_char);
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got value %0d status %0d",
                   $time, $signed(out_chan.value), out_chan.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_chan.value !== want.value) begin
            $display("%0t: value mismatch, expected %0d, got %0d",
                     $time, $signed(want.value), $signed(out_chan.value));
            errors++;
          end
          if (out_chan.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_chan.status);
            errors++;
          end
        end
      end
    end
    results_owed <= expected_results.size();
  end

endmodule

// ===== verif/rpn_stack_calculator_tb.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator_tb
// Feeds the RPN stack calculator a short directed set of expressions and then
// random ones: well-formed expressions with random digits and operators,
// overflow chains around the 32-bit limits, stack fill to the depth and one
// past it, corrupted expressions and raw noise. Both channels idle at random
// and the result side holds off once for a long stretch. Checking is done by
// rpn_eval_checker.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_tb;
  import rpn_pkg::*;

  localparam int unsigned STACK_DEPTH    = 64;
  localparam int          CHAR_TARGET    = 1550;
  localparam int          RX_HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES    = 100;
  localparam int          RUN_LIMIT      = 4_000_000;

  logic clk = 1'b0;
  logic rst_n;

  rpn_in_if  char_chan ();
  rpn_out_if result_chan ();

  int         mismatch_count;
  int         results_owed;
  int         chars_sent = 0;
  bit         tx_steady  = 1'b0;
  bit         rx_steady  = 1'b0;
  logic [7:0] expr_chars [$];
  logic [7:0] op_codes [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  string      char_pool    = " 0123456789+-*/";

  rpn_stack_calculator #(.STACK_DEPTH(STACK_DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (char_chan),
    .out_chan (result_chan)
  );

  rpn_eval_checker #(.STACK_DEPTH(STACK_DEPTH)) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (char_chan),
    .out_chan       (result_chan),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      char_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_chan.valid     <= 1'b1;
    char_chan.char_code <= ch;
    char_chan.last_char <= last;
    do @(posedge clk); while (!char_chan.ready);
    chars_sent++;
  endtask

  task automatic send_expr();
    foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1);
    expr_chars.delete();
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
  endtask

  task automatic push_digit(input int d);
    expr_chars.push_back(CH_ZERO + 8'(d));
  endtask

  function automatic logic [7:0] random_char();
    if ($urandom_range(0, 1) == 0) return char_pool[$urandom_range(0, char_pool.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // random valid expression, heavy leans on big digits and multiplies
  task automatic build_well_formed(input int max_digits, input bit heavy);
    int n_digits;
    int pushed;
    int depth;
    n_digits = $urandom_range(1, max_digits);
    pushed   = 0;
    depth    = 0;
    if ($urandom_range(0, 5) == 0) expr_chars.push_back(CH_SPACE);
    while (pushed < n_digits || depth > 1) begin
      if (expr_chars.size() > 0 && expr_chars[$] != CH_SPACE) begin
        expr_chars.push_back(CH_SPACE);
        if ($urandom_range(0, 7) == 0) expr_chars.push_back(CH_SPACE);
      end
      if (pushed < n_digits && (depth < 2 || $urandom_range(0, 2) != 0)) begin
        push_digit(heavy ? $urandom_range(6, 9) : $urandom_range(0, 9));
        pushed++;
        depth++;
      end else begin
        if (heavy && $urandom_range(0, 3) != 0) expr_chars.push_back(CH_STAR);
        else expr_chars.push_back(op_codes[$urandom_range(0, 3)]);
        depth--;
      end
    end
    if ($urandom_range(0, 5) == 0) expr_chars.push_back(CH_SPACE);
  endtask

  // builds the most negative value, then steps around the signed limits
  task automatic build_min_chain(input int tail);
    append_text("0 2 -");
    repeat (10) append_text(" 8 *");
    case (tail)
      0:       append_text(" 0 1 - /");
      1:       append_text(" 1 -");
      2:       append_text(" 0 1 - *");
      3:       ;
      4:       append_text(" 2 /");
      5:       append_text(" 1 + 0 1 - *");
      default: append_text(" 1 + 0 1 - * 1 +");
    endcase
  endtask

  task automatic build_stack_fill(input int n_push);
    repeat (n_push) begin
      push_digit($urandom_range(0, 9));
      expr_chars.push_back(CH_SPACE);
    end
    repeat (n_push - 1) begin
      expr_chars.push_back(op_codes[$urandom_range(0, 2)]);
      expr_chars.push_back(CH_SPACE);
    end
  endtask

  // result side: random stalls, steady stretches, one long hold
  initial begin
    int stall;
    int taken;
    result_chan.ready <= 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 25) stall = RX_HOLD_CYCLES;
      else stall = rx_steady ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      if (stall > 0) begin
        result_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_chan.ready <= 1'b1;
      do @(posedge clk); while (!result_chan.valid);
      taken++;
    end
  end

  initial begin
    int expr_idx;
    int pick;
    rst_n               <= 1'b0;
    char_chan.valid     <= 1'b0;
    char_chan.char_code <= '0;
    char_chan.last_char <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed expressions
    append_text("5");             send_expr();
    append_text(" ");             send_expr();
    append_text("+");             send_expr();
    append_text("9 2 / 3 * 1 +"); send_expr();
    append_text("8 0 /");         send_expr();
    append_text("12");            send_expr();
    append_text("%");             send_expr();
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);

    expr_idx = 0;
    while (chars_sent < CHAR_TARGET) begin
      if (expr_idx == 6) begin
        build_stack_fill(STACK_DEPTH);
      end else if (expr_idx == 18) begin
        build_stack_fill(STACK_DEPTH + 1);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          build_well_formed(6, 1'b0);
        end else if (pick < 65) begin
          build_well_formed(14, 1'b1);
        end else if (pick < 72) begin
          build_min_chain($urandom_range(0, 6));
        end else if (pick < 84) begin
          build_well_formed(6, 1'b0);
          expr_chars[$urandom_range(0, expr_chars.size() - 1)] = random_char();
        end else if (pick < 88) begin
          build_well_formed(4, 1'b0);
          expr_chars.push_back(CH_SPACE);
          push_digit($urandom_range(0, 9));
        end else begin
          repeat ($urandom_range(1, 6)) expr_chars.push_back(random_char());
        end
      end
      send_expr();
      expr_idx++;
    end
    char_chan.valid <= 1'b0;

    while (results_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rpn_pkg.sv
design/rpn_in_if.sv
design/rpn_out_if.sv
design/rpn_ram.sv
design/rpn_div.sv
design/rpn_stack_calculator.sv
verif/rpn_eval_checker.sv
verif/rpn_stack_calculator_tb.sv
